// ===== hdl/dda_pkg.sv =====
// Shared types and constants of the DDA line rasterizer.
`default_nettype none

package dda_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int COLOR_W        = 24;

	localparam logic [COLOR_W-1:0] COLOR_RESET = 24'hFF_FF_FF;

	localparam logic OP_START   = 1'b0;
	localparam logic OP_ADVANCE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV_X,
		ST_DIV_Y,
		ST_EMIT
	} dda_state_t;

	typedef struct packed {
		logic load_start;
		logic load_adv;
		logic div_go;
		logic div_sel_y;
		logic cap_x;
		logic cap_y;
		logic arm_line;
		logic zero_line;
		logic emit;
	} dda_cmd_t;

	typedef struct packed {
		logic line_active;
		logic steps_zero;
		logic div_done;
		logic out_free;
	} dda_stat_t;

endpackage

`default_nettype wire

// ===== hdl/dda_line_rasterizer.sv =====
// DDA line rasterizer top level: controller, datapath and their command/status link.
// Input beats on s_axis: tuser is the op (start a line or advance one pixel),
// tdata carries x_start, y_start, x_end, y_end. A start beat emits the start
// pixel; each advance beat emits the next pixel; an advance with no line
// in progress is consumed with no output beat.
// Output beats on m_axis: tdata carries pixel_x, pixel_y, pixel_color;
// tlast marks the end point of the line.
// cfg_wr_en/cfg_wr_data write the 24-bit line color; write only while idle.
// Advance: accepted, then the pixel is loaded into the output register in
// the emit step, once that register is free.
// Start: the accept step, a setup step, then one shared restoring divider
// runs twice, FRAC_BITS+1 quotient bits each, for the x and y increments,
// then the emit step. A zero-length line skips the divides.
// One beat is in work at a time; s_axis_tready is high only when idle.
// A stalled receiver holds the output register and the block waits in its
// emit step. Reset clears the line state, drops any pending output beat and
// sets the line color to white.
`default_nettype none

module dda_line_rasterizer import dda_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_wr_en,
	input  wire logic [COLOR_W-1:0]                    cfg_wr_data,
	input  wire logic                                  s_axis_tvalid,
	output logic                                       s_axis_tready,
	// x_start, y_start, x_end, y_end
	input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,
	// op
	input  wire logic                                  s_axis_tuser,
	output logic                                       m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	// pixel_x, pixel_y, pixel_color
	output logic [((2*COORD_BITS+COLOR_W+7)/8)*8-1:0]  m_axis_tdata,
	output logic                                       m_axis_tlast
);

	dda_cmd_t  cmd;
	dda_stat_t stat;

	dda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_op    (s_axis_tuser),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dda_dp #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_data       (s_axis_tdata),
		.cmd           (cmd),
		.stat          (stat),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire

// ===== hdl/dda_div.sv =====
// Restoring divider, one quotient bit per cycle, for the per-step increments.
`default_nettype none

module dda_div import dda_pkg::*; #(
	parameter int NUM_W = COORD_BITS_DEF + FRAC_BITS_DEF + 1,
	parameter int DEN_W = COORD_BITS_DEF,
	parameter int Q_W   = FRAC_BITS_DEF + 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic      [Q_W-1:0]   quo,
	output logic                  done
);

	localparam int CNT_W = $clog2(Q_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [Q_W-1:0]   quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]   part;
	logic [DEN_W+1:0] diff;
	logic             fits;

	always_comb begin
		part = {rem_q, quo_q[Q_W-1]};
		diff = {1'b0, part} - {2'b00, den_q};
		fits = ~diff[DEN_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(Q_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - {{(CNT_W-1){1'b0}}, 1'b1};
				if (cnt_q == {{(CNT_W-1){1'b0}}, 1'b1}) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= DEN_W'(num >> Q_W);
			quo_q <= num[Q_W-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : part[DEN_W-1:0];
			quo_q <= {quo_q[Q_W-2:0], fits};
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

`default_nettype wire

// ===== hdl/dda_dp.sv =====
// Datapath: endpoints, position and increment registers, pixel rounding, output beat.
`default_nettype none

module dda_dp import dda_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      cfg_wr_en,
	input  wire logic [COLOR_W-1:0]                        cfg_wr_data,
	input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]         in_data,
	input  wire dda_cmd_t                                  cmd,
	output dda_stat_t                                      stat,
	output logic                                           m_axis_tvalid,
	input  wire logic                                      m_axis_tready,
	output logic [((2*COORD_BITS+COLOR_W+7)/8)*8-1:0]      m_axis_tdata,
	output logic                                           m_axis_tlast
);

	localparam int CB     = COORD_BITS;
	localparam int FB     = FRAC_BITS;
	localparam int POS_W  = CB + FB + 1;
	localparam int Q_W    = FB + 1;
	localparam int STEP_W = FB + 2;
	localparam int NUM_W  = CB + FB + 1;
	localparam int PIX_W  = POS_W + 1 - FB;

	logic [COLOR_W-1:0] line_color_q;

	logic [POS_W-1:0]  pos_x_q, pos_y_q;
	logic [STEP_W-1:0] step_x_q, step_y_q;
	logic [CB-1:0]     ax_q, ay_q, steps_q, steps_left_q;
	logic              sx_q, sy_q;
	logic              active_q;
	logic              last_q;

	logic [CB-1:0]      px_q, py_q;
	logic [COLOR_W-1:0] color_q;
	logic               tlast_q;
	logic               tvalid_q;

	logic [CB-1:0]     xs, ys, xe, ye;
	logic [CB:0]       dx, dy;
	logic [CB-1:0]     ax, ay;
	logic [NUM_W-1:0]  div_num;
	logic [Q_W-1:0]    div_quo;
	logic              div_done;
	logic [STEP_W-1:0] quo_s, quo_neg;
	logic              out_free;
	logic              last_adv;

	function automatic logic [CB-1:0] to_pix(input logic [POS_W-1:0] pos);
		logic [POS_W:0]   r;
		logic [PIX_W-1:0] p;
		logic [CB-1:0]    res;
		r = {pos[POS_W-1], pos} + {{(POS_W+1-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};
		p = r[POS_W:FB];
		if (r[POS_W]) begin
			res = '0;
		end else if (p[CB]) begin
			res = '1;
		end else begin
			res = p[CB-1:0];
		end
		return res;
	endfunction

	always_comb begin
		xs = in_data[CB-1:0];
		ys = in_data[2*CB-1:CB];
		xe = in_data[3*CB-1:2*CB];
		ye = in_data[4*CB-1:3*CB];
		dx = {1'b0, xe} - {1'b0, xs};
		dy = {1'b0, ye} - {1'b0, ys};
		ax = dx[CB] ? CB'(-dx) : dx[CB-1:0];
		ay = dy[CB] ? CB'(-dy) : dy[CB-1:0];
		div_num = {1'b0, (cmd.div_sel_y ? ay_q : ax_q), {FB{1'b0}}}
			+ NUM_W'(steps_q >> 1);
		quo_s   = {1'b0, div_quo};
		quo_neg = -quo_s;
		out_free = ~tvalid_q | m_axis_tready;
		last_adv = (steps_left_q == {{(CB-1){1'b0}}, 1'b1});
	end

	dda_div #(
		.NUM_W (NUM_W),
		.DEN_W (CB),
		.Q_W   (Q_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_go),
		.num    (div_num),
		.den    (steps_q),
		.quo    (div_quo),
		.done   (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_color_q <= COLOR_RESET;
			active_q     <= 1'b0;
			steps_left_q <= '0;
			tvalid_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				line_color_q <= cfg_wr_data;
			end
			if (cmd.load_start || cmd.zero_line) begin
				active_q     <= 1'b0;
				steps_left_q <= '0;
			end else if (cmd.arm_line) begin
				active_q     <= 1'b1;
				steps_left_q <= steps_q;
			end else if (cmd.load_adv) begin
				steps_left_q <= steps_left_q - {{(CB-1){1'b0}}, 1'b1};
				if (last_adv) begin
					active_q <= 1'b0;
				end
			end
			if (cmd.emit) begin
				tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_start) begin
			pos_x_q <= {1'b0, xs, {FB{1'b0}}};
			pos_y_q <= {1'b0, ys, {FB{1'b0}}};
			ax_q    <= ax;
			ay_q    <= ay;
			sx_q    <= dx[CB];
			sy_q    <= dy[CB];
			steps_q <= (ax > ay) ? ax : ay;
		end else if (cmd.load_adv) begin
			pos_x_q <= pos_x_q + {{(POS_W-STEP_W){step_x_q[STEP_W-1]}}, step_x_q};
			pos_y_q <= pos_y_q + {{(POS_W-STEP_W){step_y_q[STEP_W-1]}}, step_y_q};
			last_q  <= last_adv;
		end
		if (cmd.zero_line) begin
			step_x_q <= '0;
			step_y_q <= '0;
			last_q   <= 1'b1;
		end else begin
			if (cmd.cap_x) begin
				step_x_q <= sx_q ? quo_neg : quo_s;
			end
			if (cmd.cap_y) begin
				step_y_q <= sy_q ? quo_neg : quo_s;
			end
			if (cmd.arm_line) begin
				last_q <= 1'b0;
			end
		end
		if (cmd.emit) begin
			px_q    <= to_pix(pos_x_q);
			py_q    <= to_pix(pos_y_q);
			color_q <= line_color_q;
			tlast_q <= last_q;
		end
	end

	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[CB-1:0]               = px_q;
		m_axis_tdata[2*CB-1:CB]            = py_q;
		m_axis_tdata[2*CB+COLOR_W-1:2*CB]  = color_q;
	end

	assign m_axis_tvalid = tvalid_q;
	assign m_axis_tlast  = tlast_q;

	assign stat.line_active = active_q;
	assign stat.steps_zero  = (steps_q == '0);
	assign stat.div_done    = div_done;
	assign stat.out_free    = out_free;

endmodule

`default_nettype wire

// ===== hdl/dda_ctrl.sv =====
// Controller state machine sequencing line setup, divides, advances and output beats.
`default_nettype none

module dda_ctrl import dda_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      in_op,
	output logic           in_ready,
	input  wire dda_stat_t stat,
	output dda_cmd_t       cmd
);

	dda_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_op == OP_START) begin
						cmd.load_start = 1'b1;
						state_d        = ST_PREP;
					end else if (in_op == OP_ADVANCE && stat.line_active) begin
						cmd.load_adv = 1'b1;
						state_d      = ST_EMIT;
					end
				end
			end
			ST_PREP: begin
				if (stat.steps_zero) begin
					cmd.zero_line = 1'b1;
					state_d       = ST_EMIT;
				end else begin
					cmd.div_go = 1'b1;
					state_d    = ST_DIV_X;
				end
			end
			ST_DIV_X: begin
				if (stat.div_done) begin
					cmd.cap_x     = 1'b1;
					cmd.div_go    = 1'b1;
					cmd.div_sel_y = 1'b1;
					state_d       = ST_DIV_Y;
				end
			end
			ST_DIV_Y: begin
				if (stat.div_done) begin
					cmd.cap_y    = 1'b1;
					cmd.arm_line = 1'b1;
					state_d      = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire
